[src/time_of_day_slot_scheduler_macros.svh]
// Assertion macros shared by the time-of-day slot scheduler RTL.
`ifndef TIME_OF_DAY_SLOT_SCHEDULER_MACROS_SVH
`define TIME_OF_DAY_SLOT_SCHEDULER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TODS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TODS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tods_pkg.sv]
// Types, constants and helper functions of the time-of-day slot scheduler.
package tods_pkg;

    // Table size and derived index width.
    localparam int unsigned SLOT_COUNT = 9;
    localparam int unsigned SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SLOT_COUNT - 1);

    // Field widths.
    localparam int unsigned ACTION_W   = 3;
    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned MINUTE_W   = 6;
    localparam int unsigned MIN_W      = 11;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 32;

    // Validity limits and reset schedule values.
    localparam logic [HOUR_W-1:0]     MAX_HOUR       = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0]   MAX_MINUTE     = MINUTE_W'(59);
    localparam logic [LEVEL_W-1:0]    SAFE_LEVEL     = LEVEL_W'(100);
    localparam logic [INTERVAL_W-1:0] SAFE_INTERVAL  = INTERVAL_W'(60);

    // Action codes carried in tuser.
    localparam logic [ACTION_W-1:0] ACT_STAGE   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_COMMIT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SET     = 3'd4;

    // One time slot without its report interval.
    typedef struct packed {
        logic [LEVEL_W-1:0]  lvl;
        logic [MINUTE_W-1:0] em;
        logic [HOUR_W-1:0]   eh;
        logic [MINUTE_W-1:0] sm;
        logic [HOUR_W-1:0]   sh;
    } t_slot;

    // Status returned by the slot evaluation unit.
    typedef struct packed {
        logic range_ok;
        logic wraps;
        logic hit;
    } t_slot_eval;

    // Input tdata layout, lowest field last.
    typedef struct packed {
        logic [2:0]            pad;
        logic [MINUTE_W-1:0]   now_minute;
        logic [HOUR_W-1:0]     now_hour;
        logic [INTERVAL_W-1:0] report_interval;
        logic [LEVEL_W-1:0]    level;
        logic [MINUTE_W-1:0]   end_minute;
        logic [HOUR_W-1:0]     end_hour;
        logic [MINUTE_W-1:0]   start_minute;
        logic [HOUR_W-1:0]     start_hour;
        logic [3:0]            entry_index;
    } t_in_data;

    // Output tdata layout, lowest field last.
    typedef struct packed {
        logic [1:0]            pad;
        logic [INTERVAL_W-1:0] slot_interval;
        logic [LEVEL_W-1:0]    slot_level;
        logic [3:0]            current_slot;
        logic                  in_slot;
        logic                  accepted;
    } t_out_data;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COPY,
        ST_RESULT
    } t_state;

    // Minutes of the day as hour*60+minute, built from two shifts.
    function automatic logic [MIN_W-1:0] tod_minutes(input logic [HOUR_W-1:0] h,
                                                     input logic [MINUTE_W-1:0] m);
        logic [MIN_W-1:0] h64;
        logic [MIN_W-1:0] h4;
        h64 = {h, 6'b0};
        h4  = {4'b0, h, 2'b0};
        return h64 - h4 + {5'b0, m};
    endfunction

    // Safe schedule entry: slot i runs from i+1:00 to i+2:00, the last ends at 1:00.
    function automatic t_slot safe_slot(input int unsigned idx);
        t_slot s;
        s.sh  = HOUR_W'(idx + 1);
        s.sm  = '0;
        s.eh  = (idx == SLOT_COUNT - 1) ? HOUR_W'(1) : HOUR_W'(idx + 2);
        s.em  = '0;
        s.lvl = SAFE_LEVEL;
        return s;
    endfunction

endpackage

[src/time_of_day_slot_scheduler.sv]
// Top level of the time-of-day slot scheduler.
//
// Items arrive on the slave stream: tuser carries the action code, tdata the slot
// index, the staged slot fields and the current time. Every transfer in gives
// exactly one transfer out on the master stream with the accepted flag, the
// in-slot flag, the current slot index and that slot's level and interval.
// One item is taken at a time; tready is low while an item is being worked on.
// Stage, check, advance and set go from the input transfer through the result
// state into the output register. A commit first makes one pass over the
// staged table through the shared evaluation unit, which checks ranges, flags
// more than one slot running past midnight and finds the first slot holding
// the current time; only when the staged table is valid does a second pass
// copy it into the active one, one slot per cycle, before the result state.
// A new item is taken once the previous result is loaded into the output
// register. A stalled receiver holds the result in the output register; the
// next item may still be taken, but its result waits until the previous one
// leaves.
// A synchronous active-low reset loads the safe schedule into both tables,
// sets the current slot to zero and empties the output register.
module time_of_day_slot_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // Fields from bit 0 up: entry_index, start_hour, start_minute, end_hour,
    // end_minute, level, report_interval, now_hour, now_minute, zero fill.
    input  logic [tods_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0 up: action.
    input  logic [tods_pkg::ACTION_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // Fields from bit 0 up: accepted, in_slot, current_slot, slot_level,
    // slot_interval, zero fill.
    output logic [tods_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import tods_pkg::*;
    `include "time_of_day_slot_scheduler_macros.svh"

    t_state                  r_state;
    t_state                  n_state;
    logic [SLOT_IDX_W-1:0]   r_cnt;
    logic [SLOT_IDX_W-1:0]   r_task;
    logic [SLOT_IDX_W-1:0]   r_found_idx;
    logic                    r_found;
    logic                    r_wrap_seen;
    logic                    r_multi_wrap;
    logic                    r_range_bad;
    logic                    r_acc;
    logic [MIN_W-1:0]        r_now_min;
    t_slot                   r_staged     [SLOT_COUNT];
    logic [INTERVAL_W-1:0]   r_staged_int [SLOT_COUNT];
    t_slot                   r_active     [SLOT_COUNT];
    logic [INTERVAL_W-1:0]   r_active_int [SLOT_COUNT];
    logic                    r_out_valid;
    t_out_data               r_out_data;

    t_in_data                in_data;
    logic                    in_xfer;
    logic                    idx_ok;
    logic [SLOT_IDX_W-1:0]   in_idx;
    logic                    cnt_last;
    logic                    out_load;
    logic                    range_bad_n;
    logic                    multi_wrap_n;
    t_slot                   eval_slot;
    t_slot_eval              eval_res;

    // Input decode.
    assign in_data         = t_in_data'(i_s_axis_tdata);
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign idx_ok          = ({1'b0, in_data.entry_index} < 5'(SLOT_COUNT));
    assign in_idx          = in_data.entry_index[SLOT_IDX_W-1:0];
    assign cnt_last        = (r_cnt == LAST_IDX);

    // The evaluation unit sees the staged table in every state but the result state, where it sees the current slot.
    assign eval_slot = (r_state == ST_RESULT) ? r_active[r_task] : r_staged[r_cnt];

    tods_slot_eval u_eval (
        .i_slot    (eval_slot),
        .i_now_min (r_now_min),
        .o_eval    (eval_res)
    );

    // Running validity flags including the slot under test.
    assign range_bad_n  = r_range_bad || !eval_res.range_ok;
    assign multi_wrap_n = r_multi_wrap || (r_wrap_seen && eval_res.wraps);

    // Next state and output load strobe.
    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_s_axis_tuser == ACT_COMMIT) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (cnt_last) begin
                    n_state = (range_bad_n || multi_wrap_n) ? ST_RESULT : ST_COPY;
                end
            end
            ST_COPY: begin
                if (cnt_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer registers, current task and both slot tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task       <= '0;
            r_cnt        <= '0;
            r_found      <= 1'b0;
            r_found_idx  <= '0;
            r_wrap_seen  <= 1'b0;
            r_multi_wrap <= 1'b0;
            r_range_bad  <= 1'b0;
            r_acc        <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_staged[i]     <= safe_slot(i);
                r_active[i]     <= safe_slot(i);
                r_staged_int[i] <= SAFE_INTERVAL;
                r_active_int[i] <= SAFE_INTERVAL;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_now_min    <= tod_minutes(in_data.now_hour, in_data.now_minute);
                        r_cnt        <= '0;
                        r_found      <= 1'b0;
                        r_wrap_seen  <= 1'b0;
                        r_multi_wrap <= 1'b0;
                        r_range_bad  <= 1'b0;
                        case (i_s_axis_tuser)
                            ACT_STAGE: begin
                                r_acc <= idx_ok;
                                if (idx_ok) begin
                                    r_staged[in_idx].sh  <= in_data.start_hour;
                                    r_staged[in_idx].sm  <= in_data.start_minute;
                                    r_staged[in_idx].eh  <= in_data.end_hour;
                                    r_staged[in_idx].em  <= in_data.end_minute;
                                    r_staged[in_idx].lvl <= in_data.level;
                                    r_staged_int[in_idx] <= in_data.report_interval;
                                end
                            end
                            ACT_CHECK: begin
                                r_acc <= 1'b1;
                            end
                            ACT_ADVANCE: begin
                                r_task <= (r_task == LAST_IDX) ? '0 : r_task + 1'b1;
                                r_acc  <= 1'b1;
                            end
                            ACT_SET: begin
                                r_acc <= idx_ok;
                                if (idx_ok) begin
                                    r_task <= in_idx;
                                end
                            end
                            default: begin
                                r_acc <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // One staged slot per cycle through the shared unit.
                    r_range_bad  <= range_bad_n;
                    r_multi_wrap <= multi_wrap_n;
                    r_wrap_seen  <= r_wrap_seen || eval_res.wraps;
                    if (eval_res.hit && !r_found) begin
                        r_found     <= 1'b1;
                        r_found_idx <= r_cnt;
                    end
                    r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
                end
                ST_COPY: begin
                    // Adopt the staged table one slot per cycle.
                    r_active[r_cnt]     <= r_staged[r_cnt];
                    r_active_int[r_cnt] <= r_staged_int[r_cnt];
                    r_cnt               <= cnt_last ? '0 : r_cnt + 1'b1;
                    if (cnt_last) begin
                        r_acc <= 1'b1;
                        if (r_found) begin
                            r_task <= r_found_idx;
                        end
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // Output register: holds a result until the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.pad           <= '0;
            r_out_data.accepted      <= r_acc;
            r_out_data.in_slot       <= eval_res.hit;
            r_out_data.current_slot  <= 4'(r_task);
            r_out_data.slot_level    <= r_active[r_task].lvl;
            r_out_data.slot_interval <= r_active_int[r_task];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_data);

    // Checks on the sequencer.
    `TODS_ASSERT_SAME(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !o_s_axis_tready, "input ready while busy")
    `TODS_ASSERT_NEXT(a_xfer_starts_work, i_clk, i_rst_n, in_xfer, r_state != ST_IDLE, "input transfer did not start work")
    `TODS_ASSERT_SAME(a_copy_only_valid, i_clk, i_rst_n, r_state == ST_COPY, !r_range_bad && !r_multi_wrap, "table copied after failed check")
    `TODS_ASSERT_SAME(a_task_in_range, i_clk, i_rst_n, r_out_valid, r_task <= LAST_IDX, "current slot out of range")

endmodule

[src/tods_slot_eval.sv]
// Shared slot evaluation unit: range check, midnight wrap and time containment.
module tods_slot_eval (
    input  tods_pkg::t_slot             i_slot,
    input  logic [tods_pkg::MIN_W-1:0]  i_now_min,
    output tods_pkg::t_slot_eval        o_eval
);
    import tods_pkg::*;

    logic [MIN_W-1:0] lo_min;
    logic [MIN_W-1:0] hi_min;

    // Start and end as minutes of the day.
    assign lo_min = tod_minutes(i_slot.sh, i_slot.sm);
    assign hi_min = tod_minutes(i_slot.eh, i_slot.em);

    // Hours and minutes within the clock range.
    assign o_eval.range_ok = (i_slot.sh <= MAX_HOUR) && (i_slot.eh <= MAX_HOUR) &&
                             (i_slot.sm <= MAX_MINUTE) && (i_slot.em <= MAX_MINUTE);

    // A slot whose start is not before its end counts as running past midnight.
    assign o_eval.wraps = (lo_min >= hi_min);

    // Inclusive containment; an inverted slot wraps round midnight.
    assign o_eval.hit = (lo_min <= hi_min) ?
                        ((i_now_min >= lo_min) && (i_now_min <= hi_min)) :
                        ((i_now_min >= lo_min) || (i_now_min <= hi_min));

endmodule
